[rtl/core/bhs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhs_pkg
// Shared codes and types for the bounded history stack.
// ----------------------------------------------------------------------------
package bhs_pkg;

    // Command codes carried by an input item.
    localparam logic [1:0] CMD_PUSH   = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    // Status codes reported with every result item.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    // Widths of the limit register (and of the reported count) and of the position field.
    localparam int unsigned LIMIT_BITS = 6;
    localparam int unsigned POS_BITS   = 5;

    // Reset value of the history limit.
    localparam logic [LIMIT_BITS-1:0] RESET_LIMIT = 6'd30;

    // Controller states.
    typedef enum logic {
        STATE_IDLE,
        STATE_MOVE
    } state_t;

endpackage

[rtl/core/bhs_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhs_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module bhs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/bounded_history_stack.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_history_stack
// Bounded LIFO of entry tags held in a circular RAM. A push moves the head
// pointer back and writes one word; a removal moves the entries below the
// removed one up by one place, one RAM word per cycle.
// ----------------------------------------------------------------------------
// Results: push, clear and unused commands, and removals that fail or take the
//   oldest entry, load their result item in the cycle after acceptance; any
//   other removal reports once its move loop through the RAM ports is done.
// Throughput: one item at a time; the next item is taken once the current
//   result is loaded and the output register is free (or being drained).
// Reset: synchronous, active low; empties the stack and loads a limit of 30.
//   RAM contents are not cleared; only written entries are ever read.
module bounded_history_stack #(
    parameter int DEPTH    = 32,
    parameter int TAG_BITS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,

    // Configuration write channel.
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [5:0]          cfg_data,

    // Input item channel.
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_command,
    input  logic [TAG_BITS-1:0] s_entry_tag,
    input  logic [4:0]          s_position,

    // Result item channel.
    output logic                m_valid,
    input  logic                m_ready,
    output logic [TAG_BITS-1:0] m_top_tag,
    output logic [5:0]          m_entry_count,
    output logic                m_evicted_oldest,
    output logic [1:0]          m_status
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CW0   = $clog2(DEPTH + 1);
    localparam int CW    = (CW0 > bhs_pkg::LIMIT_BITS) ? CW0 : bhs_pkg::LIMIT_BITS;
    localparam int LB    = bhs_pkg::LIMIT_BITS;

    // Physical RAM address of the entry at a logical distance from the top.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                           input logic [CW-1:0] idx);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(idx);
        if (sum >= (CW+1)'(DEPTH)) begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    bhs_pkg::state_t      state_reg, state_next;
    logic [AW-1:0]        head_reg, head_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [TAG_BITS-1:0]  top_reg, top_next;
    logic [LB-1:0]        limit_reg;
    logic [CW-1:0]        src_reg, src_next;
    logic                 pend_reg, pend_next;
    logic [AW-1:0]        wr_addr_reg, wr_addr_next;
    logic                 wr_top_reg, wr_top_next;

    logic                 m_valid_reg, m_valid_next;
    logic [TAG_BITS-1:0]  m_top_tag_reg, m_top_tag_next;
    logic [5:0]           m_count_reg, m_count_next;
    logic                 m_evicted_reg, m_evicted_next;
    logic [1:0]           m_status_reg, m_status_next;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [TAG_BITS-1:0]  ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [TAG_BITS-1:0]  ram_rdata;

    logic                 out_free;
    logic                 in_fire;
    logic [CW-1:0]        limit_ext;
    logic [CW-1:0]        eff_limit;
    logic [CW-1:0]        pos_ext;
    logic [CW-1:0]        count_dec;

    bhs_ram #(
        .WIDTH (TAG_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Handshakes.
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == bhs_pkg::STATE_IDLE) && out_free;
    assign in_fire   = s_valid && s_ready;

    // Effective limit: zero acts as one, anything above the depth as the depth.
    assign limit_ext = CW'(limit_reg);
    always_comb begin
        if (limit_reg == '0) begin
            eff_limit = CW'(1);
        end else if (limit_ext > CW'(DEPTH)) begin
            eff_limit = CW'(DEPTH);
        end else begin
            eff_limit = limit_ext;
        end
    end

    assign pos_ext   = CW'(s_position);
    assign count_dec = count_reg - CW'(1);

    // Next state, RAM control and result loading.
    always_comb begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        top_next       = top_reg;
        src_next       = src_reg;
        pend_next      = pend_reg;
        wr_addr_next   = wr_addr_reg;
        wr_top_next    = wr_top_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_top_tag_next = m_top_tag_reg;
        m_count_next   = m_count_reg;
        m_evicted_next = m_evicted_reg;
        m_status_next  = m_status_reg;
        ram_we         = 1'b0;
        ram_waddr      = wr_addr_reg;
        ram_wdata      = ram_rdata;
        ram_raddr      = phys(head_reg, src_reg);

        case (state_reg)
            bhs_pkg::STATE_IDLE: begin
                if (in_fire) begin
                    m_evicted_next = 1'b0;
                    m_status_next  = bhs_pkg::STATUS_OK;
                    m_count_next   = count_reg[5:0];
                    m_top_tag_next = (count_reg != '0) ? top_reg : '0;
                    m_valid_next   = 1'b1;
                    case (s_command)
                        bhs_pkg::CMD_PUSH: begin
                            // New top one slot before the old head; a
                            // stack at its limit drops its oldest entry instead of growing.
                            head_next = (head_reg == '0) ? AW'(DEPTH - 1)
                                                         : head_reg - AW'(1);
                            ram_we    = 1'b1;
                            ram_waddr = head_next;
                            ram_wdata = s_entry_tag;
                            top_next  = s_entry_tag;
                            if (count_reg >= eff_limit) begin
                                m_evicted_next = 1'b1;
                            end else begin
                                count_next = count_reg + CW'(1);
                            end
                            m_count_next   = count_next[5:0];
                            m_top_tag_next = s_entry_tag;
                        end
                        bhs_pkg::CMD_REMOVE: begin
                            if (count_reg == '0) begin
                                m_status_next = bhs_pkg::STATUS_EMPTY;
                            end else if (pos_ext >= count_reg) begin
                                m_status_next = bhs_pkg::STATUS_RANGE;
                            end else if (pos_ext + CW'(1) < count_reg) begin
                                // Entries below the removed one must move up.
                                m_valid_next = m_valid_reg && !m_ready;
                                state_next   = bhs_pkg::STATE_MOVE;
                                src_next     = pos_ext + CW'(1);
                                pend_next    = 1'b0;
                            end else begin
                                // Removing the oldest entry needs no moves.
                                count_next     = count_dec;
                                m_count_next   = count_dec[5:0];
                                m_top_tag_next = (count_dec != '0) ? top_reg : '0;
                            end
                        end
                        bhs_pkg::CMD_CLEAR: begin
                            count_next     = '0;
                            m_count_next   = '0;
                            m_top_tag_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            bhs_pkg::STATE_MOVE: begin
                // Read the next source entry; its data is written one place up
                // in the following cycle.
                if (src_reg < count_reg) begin
                    src_next     = src_reg + CW'(1);
                    pend_next    = 1'b1;
                    wr_addr_next = phys(head_reg, src_reg - CW'(1));
                    wr_top_next  = (src_reg == CW'(1));
                end else begin
                    pend_next = 1'b0;
                end

                if (pend_reg) begin
                    ram_we = 1'b1;
                    if (wr_top_reg) begin
                        top_next = ram_rdata;
                    end
                end

                // All moves written: shrink the stack and report.
                if (!pend_reg && (src_reg >= count_reg) && out_free) begin
                    count_next     = count_dec;
                    m_valid_next   = 1'b1;
                    m_count_next   = count_dec[5:0];
                    m_top_tag_next = top_reg;
                    m_evicted_next = 1'b0;
                    m_status_next  = bhs_pkg::STATUS_OK;
                    state_next     = bhs_pkg::STATE_IDLE;
                end
            end

            default: begin
                state_next = bhs_pkg::STATE_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bhs_pkg::STATE_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            limit_reg   <= bhs_pkg::RESET_LIMIT;
            src_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            src_reg     <= src_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                limit_reg <= cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        top_reg       <= top_next;
        wr_addr_reg   <= wr_addr_next;
        wr_top_reg    <= wr_top_next;
        m_top_tag_reg <= m_top_tag_next;
        m_count_reg   <= m_count_next;
        m_evicted_reg <= m_evicted_next;
        m_status_reg  <= m_status_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_top_tag        = m_top_tag_reg;
    assign m_entry_count    = m_count_reg;
    assign m_evicted_oldest = m_evicted_reg;
    assign m_status         = m_status_reg;

endmodule
